// ----- design/wcd_pkg.sv -----
package wcd_pkg;

    localparam int NUM_CONTACTS_DEF = 6;
    localparam int WINDOW_BYTES_DEF = 4;

    localparam int PIN_W      = 6;
    localparam int TH_W       = 6;
    localparam int NOTE_W     = 7;
    localparam int PACK_W     = 42;
    localparam int CHAN_W     = 4;
    localparam int CIDX_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int EVT_IDX_W  = 4;
    localparam int PACKED_CNT = 6;

    // tick records buffered between the counters and the output port
    localparam int EVQ_DEPTH  = 4;

    localparam logic [TH_W-1:0]   PRESS_TH_RST   = 6'd24;
    localparam logic [TH_W-1:0]   RELEASE_TH_RST = 6'd8;
    localparam logic [PACK_W-1:0] NOTES_RST      = 42'd1799956927268;
    localparam logic [PACK_W-1:0] VELS_RST       = 42'd2770422998490;
    localparam logic [CHAN_W-1:0] CHAN_RST       = 4'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_TH     = 3'd0,
        CFG_RELEASE_TH   = 3'd1,
        CFG_NOTE_NUMBERS = 3'd2,
        CFG_NOTE_VELS    = 3'd3,
        CFG_MIDI_CHANNEL = 3'd4
    } t_cfg_idx;

    // one event handed from the queue to the output port
    typedef struct packed {
        logic [EVT_IDX_W-1:0] idx;
        logic                 note_on;
        logic                 last;
    } t_evt;

    // 7-bit slot of a packed note register; contacts past the sixth read zero
    function automatic logic [NOTE_W-1:0] field7(input logic [PACK_W-1:0] packed_reg,
                                                 input logic [EVT_IDX_W-1:0] idx);
        logic [NOTE_W-1:0] res;
        res = '0;
        if (idx < EVT_IDX_W'(PACKED_CNT)) begin
            res = packed_reg[idx * NOTE_W +: NOTE_W];
        end
        return res;
    endfunction

endpackage

// ----- design/windowed_contact_debouncer_top.sv -----
// Debounces six active-low contacts (more with NUM_CONTACTS) over a sliding window of
// WINDOW_BYTES*8 ticks and reports each press or release as a note event. One tick is
// taken per clock while the event queue (4 ticks deep) has room; the sample history
// sits in a RAM read when the tick is accepted, counters and pressed flags are updated
// in the second stage once the word is back, and the tick's changes then go into the
// event queue. Events leave one per cycle through a single output register while the
// output is not stalled by i_ready, and o_last_event marks the last event of a tick.
// Ticks that change nothing produce no events. History reads as all zeros after reset
// through per-slot valid bits, so no clearing pass.
module windowed_contact_debouncer_top
    import wcd_pkg::*;
#(
    parameter int NUM_CONTACTS = NUM_CONTACTS_DEF,
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIN_W-1:0]     i_pin_levels,

    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CIDX_W-1:0]    o_contact_index,
    output logic                 o_note_on,
    output logic [NOTE_W-1:0]    o_note_number,
    output logic [NOTE_W-1:0]    o_velocity,
    output logic [CHAN_W-1:0]    o_channel,
    output logic                 o_last_event,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PACK_W-1:0]    i_cfg_data
);

    localparam int WS    = WINDOW_BYTES * 8;
    localparam int PW    = $clog2(WS);
    localparam int CW    = $clog2(WS + 1);
    localparam int CMP_W = (CW > TH_W) ? CW : TH_W;
    localparam int LW    = $clog2(EVQ_DEPTH + 1);

    // configuration
    logic [TH_W-1:0]   r_press_th;
    logic [TH_W-1:0]   r_release_th;
    logic [PACK_W-1:0] r_notes;
    logic [PACK_W-1:0] r_vels;
    logic [CHAN_W-1:0] r_chan;

    // window and debounce state
    logic [PW-1:0]           r_pos;
    logic [WS-1:0]           r_hist_vld;
    logic [CW-1:0]           r_cnt [NUM_CONTACTS];
    logic [CW-1:0]           n_cnt [NUM_CONTACTS];
    logic [NUM_CONTACTS-1:0] r_pressed;
    logic [NUM_CONTACTS-1:0] n_pressed;

    // second stage: history word is back from the RAM
    logic                    r_s1_valid;
    logic [PW-1:0]           r_s1_pos;
    logic [NUM_CONTACTS-1:0] r_s1_closed;
    logic                    r_s1_old_vld;

    logic                    in_acc;
    logic [NUM_CONTACTS+PIN_W-1:0] pins_ext;
    logic [NUM_CONTACTS-1:0] closed;
    logic [NUM_CONTACTS-1:0] rd_word;
    logic [NUM_CONTACTS-1:0] old_word;
    logic [NUM_CONTACTS-1:0] chg;
    logic [NUM_CONTACTS-1:0] chg_on;
    logic [CW:0]             sum;
    logic [LW-1:0]           evq_level;
    logic                    evq_valid;
    t_evt                    evq_evt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_th   <= PRESS_TH_RST;
            r_release_th <= RELEASE_TH_RST;
            r_notes      <= NOTES_RST;
            r_vels       <= VELS_RST;
            r_chan       <= CHAN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRESS_TH:     r_press_th   <= i_cfg_data[TH_W-1:0];
                CFG_RELEASE_TH:   r_release_th <= i_cfg_data[TH_W-1:0];
                CFG_NOTE_NUMBERS: r_notes      <= i_cfg_data;
                CFG_NOTE_VELS:    r_vels       <= i_cfg_data;
                CFG_MIDI_CHANNEL: r_chan       <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // room for this tick plus the one already in the second stage
    assign o_ready = ({1'b0, evq_level} + (LW+1)'(r_s1_valid)) < (LW+1)'(EVQ_DEPTH);
    assign in_acc  = i_valid && o_ready;

    // contacts without a pin read low, i.e. closed
    assign pins_ext = {{NUM_CONTACTS{1'b0}}, i_pin_levels};
    assign closed   = ~pins_ext[NUM_CONTACTS-1:0];

    wcd_ram #(
        .WIDTH (NUM_CONTACTS),
        .DEPTH (WS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_pos),
        .i_wdata (r_s1_closed),
        .i_re    (in_acc),
        .i_raddr (r_pos),
        .o_rdata (rd_word)
    );

    assign old_word = r_s1_old_vld ? rd_word : '0;

    always_comb begin
        n_pressed = r_pressed;
        chg       = '0;
        chg_on    = '0;
        sum       = '0;
        for (int i = 0; i < NUM_CONTACTS; i++) begin
            sum = {1'b0, r_cnt[i]} + (CW+1)'(r_s1_closed[i]);
            if (old_word[i] && (sum != '0)) begin
                sum = sum - 1'b1;
            end
            n_cnt[i] = sum[CW-1:0];
            if (r_pressed[i] && (CMP_W'(n_cnt[i]) < CMP_W'(r_release_th))) begin
                chg[i]       = 1'b1;
                n_pressed[i] = 1'b0;
            end else if (!r_pressed[i] && (CMP_W'(n_cnt[i]) > CMP_W'(r_press_th))) begin
                chg[i]       = 1'b1;
                chg_on[i]    = 1'b1;
                n_pressed[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hist_vld <= '0;
            r_pressed  <= '0;
            r_s1_valid <= 1'b0;
            for (int i = 0; i < NUM_CONTACTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_s1_valid <= in_acc;
            if (in_acc) begin
                r_pos <= (r_pos == PW'(WS - 1)) ? '0 : r_pos + 1'b1;
            end
            if (r_s1_valid) begin
                r_hist_vld[r_s1_pos] <= 1'b1;
                r_pressed            <= n_pressed;
                for (int i = 0; i < NUM_CONTACTS; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pos     <= r_pos;
            r_s1_closed  <= closed;
            r_s1_old_vld <= r_hist_vld[r_pos];
        end
    end

    wcd_evq #(
        .NUM_CONTACTS (NUM_CONTACTS)
    ) u_evq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid && (chg != '0)),
        .i_push_mask (chg),
        .i_push_on   (chg_on),
        .o_level     (evq_level),
        .o_valid     (evq_valid),
        .i_ready     (i_ready),
        .o_evt       (evq_evt)
    );

    assign o_valid         = evq_valid;
    assign o_contact_index = evq_evt.idx[CIDX_W-1:0];
    assign o_note_on       = evq_evt.note_on;
    assign o_note_number   = field7(r_notes, evq_evt.idx);
    assign o_velocity      = evq_evt.note_on ? field7(r_vels, evq_evt.idx) : '0;
    assign o_channel       = r_chan;
    assign o_last_event    = evq_evt.last;

endmodule

// ----- design/wcd_ram.sv -----
module wcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/wcd_evq.sv -----
module wcd_evq
    import wcd_pkg::*;
#(
    parameter int NUM_CONTACTS = NUM_CONTACTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [NUM_CONTACTS-1:0]            i_push_mask,
    input  logic [NUM_CONTACTS-1:0]            i_push_on,
    output logic [$clog2(EVQ_DEPTH+1)-1:0]     o_level,
    output logic                               o_valid,
    input  logic                               i_ready,
    output t_evt                               o_evt
);

    localparam int PW = $clog2(EVQ_DEPTH);
    localparam int LW = $clog2(EVQ_DEPTH + 1);
    localparam int SW = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;

    logic [NUM_CONTACTS-1:0] r_mask [EVQ_DEPTH];
    logic [NUM_CONTACTS-1:0] r_on   [EVQ_DEPTH];
    logic [PW-1:0]           r_rd;
    logic [PW-1:0]           r_wr;
    logic [LW-1:0]           r_cnt;
    logic                    r_valid;
    t_evt                    r_evt;

    logic [NUM_CONTACTS-1:0] head_mask;
    logic [NUM_CONTACTS-1:0] rest_mask;
    logic [EVT_IDX_W-1:0]    sel;
    logic [SW-1:0]           sel_bit;
    logic                    emit;
    logic                    pop;

    assign head_mask = r_mask[r_rd];

    // lowest pending contact of the head tick goes first
    always_comb begin
        sel       = '0;
        sel_bit   = '0;
        rest_mask = head_mask;
        for (int i = NUM_CONTACTS - 1; i >= 0; i--) begin
            if (head_mask[i]) begin
                sel     = EVT_IDX_W'(i);
                sel_bit = SW'(i);
            end
        end
        rest_mask[sel_bit] = 1'b0;
    end

    assign emit = (r_cnt != '0) && (!r_valid || i_ready);
    assign pop  = emit && (rest_mask == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + LW'(i_push) - LW'(pop);
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mask[r_wr] <= i_push_mask;
            r_on[r_wr]   <= i_push_on;
        end
        if (emit) begin
            r_evt.idx     <= sel;
            r_evt.note_on <= r_on[r_rd][sel_bit];
            r_evt.last    <= (rest_mask == '0);
            if (rest_mask != '0) begin
                r_mask[r_rd] <= rest_mask;
            end
        end
    end

    assign o_level = r_cnt;
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

endmodule

// ----- design/wcd_chk.sv -----
module wcd_chk
    import wcd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [CIDX_W-1:0]    o_contact_index,
    input logic                 o_note_on,
    input logic [NOTE_W-1:0]    o_velocity,
    input logic                 o_last_event
);

    // stalled event keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_contact_index)
            && $stable(o_note_on) && $stable(o_last_event))
        else $error("output event changed while stalled");

    a_release_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_note_on |-> o_velocity == '0)
        else $error("note-off carries a velocity");

    // rest of a tick's events follow without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_event |=> o_valid)
        else $error("gap inside a tick's events");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("event right after reset");

endmodule

bind windowed_contact_debouncer_top wcd_chk u_wcd_chk (.*);
